// ===== rtl/trtc_pkg.sv =====
// Package for the TFTP read transfer control block: item types, event,
// action and end-reason codes, phase enum and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package trtc_pkg;

  // Event codes carried in the mode field
  localparam logic [2:0] EV_START       = 3'd0;
  localparam logic [2:0] EV_BLOCK_READY = 3'd1;
  localparam logic [2:0] EV_TICK        = 3'd2;
  localparam logic [2:0] EV_PACKET      = 3'd3;
  localparam logic [2:0] EV_REFUSED     = 3'd4;

  // Result action codes
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_FETCH = 2'd1;
  localparam logic [1:0] ACT_SEND  = 2'd2;
  localparam logic [1:0] ACT_CLOSE = 2'd3;

  // End reasons
  localparam logic [1:0] END_RUNNING  = 2'd0;
  localparam logic [1:0] END_FINISHED = 2'd1;
  localparam logic [1:0] END_RETRIES  = 2'd2;
  localparam logic [1:0] END_REFUSED  = 2'd3;

  // Protocol constants
  localparam logic [15:0] OPC_ACK        = 16'd4;
  localparam logic [9:0]  HEADER_BYTES   = 10'd4;
  localparam logic [15:0] START_BLOCK    = 16'd1;
  localparam logic [3:0]  RETRY_LIMIT_RST = 4'd5;
  localparam logic [15:0] TIMEOUT_RST    = 16'd10;
  localparam logic [15:0] TIMER_MAX      = 16'hFFFF;

  // Configuration register indexes
  localparam logic REG_RETRY_LIMIT   = 1'b0;
  localparam logic REG_TIMEOUT_TICKS = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FETCH = 2'd1,
    PH_WAIT  = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [9:0]  data_length;
    logic [15:0] packet_opcode;
    logic [15:0] ack_block;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] block_number;
    logic [9:0]  packet_length;
    logic [1:0]  end_reason;
  } out_item_t;

endpackage

// ===== rtl/tftp_read_transfer_control_top.sv =====
// Top level of the TFTP read transfer control block (sender side).
// Depends on trtc_pkg for item types, codes and the phase enum.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid_i, in_ready_o, in_item_i    | event items in
//  out     | out_valid_o, out_ready_i, out_item_o | one result item per event
//  cfg     | cfg_we_i, cfg_index_i, cfg_wdata_i   | register writes
//
// Each item is decoded and applied to the transfer state in the cycle it is
// accepted; its result is in the output register the next cycle.
// One item per cycle is sustained; the only limit is the single result register.
// A stalled result holds in_ready_o low only while out_ready_i is low.
// Reset puts the transfer in idle at block 1 with limit 5 and timeout 10.
`timescale 1ns / 1ps

module tftp_read_transfer_control_top
  import trtc_pkg::*;
#(
  parameter int BLOCK_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_wdata_i
);

  // Full-size block length as held in the 10-bit length register
  localparam logic [10:0] BlockBytesW = 11'(BLOCK_BYTES);
  localparam logic [9:0]  BlockLen    = BlockBytesW[9:0];

  // Configuration registers
  logic [3:0]  retry_limit_q;
  logic [15:0] timeout_ticks_q;

  // Transfer state
  phase_e      phase_q, phase_d;
  logic [15:0] cur_block_q, cur_block_d;
  logic [3:0]  retry_q, retry_d;
  logic [15:0] timer_q, timer_d;
  logic [9:0]  last_len_q, last_len_d;

  // Result register
  logic        out_valid_q;
  out_item_t   out_item_q;
  out_item_t   res;

  logic        in_accept;
  logic        is_start, blk_ok, tick_ok, pkt_ok, ref_ok;
  logic [15:0] timer_inc;
  logic        timeout, pkt_bad, retry, retry_close, ack_more, ack_done;
  logic [3:0]  retry_inc;
  logic [9:0]  len_sat;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  // Event decode against the current phase
  assign is_start = (in_item_i.mode == EV_START);
  assign blk_ok   = (in_item_i.mode == EV_BLOCK_READY) && (phase_q == PH_FETCH);
  assign tick_ok  = (in_item_i.mode == EV_TICK) && (phase_q == PH_WAIT);
  assign pkt_ok   = (in_item_i.mode == EV_PACKET) && (phase_q == PH_WAIT);
  assign ref_ok   = (in_item_i.mode == EV_REFUSED) &&
                    ((phase_q == PH_FETCH) || (phase_q == PH_WAIT));

  // Saturating timer and timeout check
  assign timer_inc = (timer_q < TIMER_MAX) ? timer_q + 16'd1 : timer_q;
  assign timeout   = tick_ok && (timer_inc >= timeout_ticks_q);

  // ACK check: wrong opcode or stale block number counts as a retry
  assign pkt_bad = (in_item_i.packet_opcode != OPC_ACK) ||
                   (in_item_i.ack_block < cur_block_q);
  assign retry       = timeout || (pkt_ok && pkt_bad);
  assign retry_inc   = retry_q + 4'd1;
  assign retry_close = !(retry_inc < retry_limit_q);
  assign ack_more    = pkt_ok && !pkt_bad && (last_len_q == BlockLen);
  assign ack_done    = pkt_ok && !pkt_bad && (last_len_q != BlockLen);

  // Oversized read lengths clip to the block size
  assign len_sat = ({1'b0, in_item_i.data_length} > BlockBytesW) ?
                   BlockLen : in_item_i.data_length;

  // Next transfer state
  always_comb begin
    phase_d     = phase_q;
    cur_block_d = cur_block_q;
    retry_d     = retry_q;
    timer_d     = timer_q;
    last_len_d  = last_len_q;
    if (is_start) begin
      phase_d     = PH_FETCH;
      cur_block_d = START_BLOCK;
      retry_d     = 4'd0;
      timer_d     = 16'd0;
    end else if (blk_ok) begin
      phase_d    = PH_WAIT;
      last_len_d = len_sat;
      retry_d    = 4'd0;
      timer_d    = 16'd0;
    end else if (ref_ok || ack_done) begin
      phase_d = PH_DONE;
    end else if (ack_more) begin
      phase_d     = PH_FETCH;
      cur_block_d = cur_block_q + 16'd1;
    end else begin
      if (tick_ok) timer_d = timer_inc;
      if (retry) begin
        retry_d = retry_inc;
        if (retry_close) phase_d = PH_DONE;
        else             timer_d = 16'd0;
      end
    end
  end

  // Result item for the accepted event
  always_comb begin
    res               = '0;
    res.action        = ACT_NONE;
    res.end_reason    = END_RUNNING;
    res.block_number  = cur_block_d;
    if (is_start || ack_more) begin
      res.action = ACT_FETCH;
    end else if (blk_ok) begin
      res.action        = ACT_SEND;
      res.packet_length = HEADER_BYTES + len_sat;
    end else if (retry && !retry_close) begin
      res.action        = ACT_SEND;
      res.packet_length = HEADER_BYTES + last_len_q;
    end else if (retry) begin
      res.action     = ACT_CLOSE;
      res.end_reason = END_RETRIES;
    end else if (ack_done) begin
      res.action     = ACT_CLOSE;
      res.end_reason = END_FINISHED;
    end else if (ref_ok) begin
      res.action     = ACT_CLOSE;
      res.end_reason = END_REFUSED;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q   <= RETRY_LIMIT_RST;
      timeout_ticks_q <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_RETRY_LIMIT:   retry_limit_q   <= cfg_wdata_i[3:0];
        REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Transfer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cur_block_q <= START_BLOCK;
      retry_q     <= 4'd0;
      timer_q     <= 16'd0;
      last_len_q  <= 10'd0;
    end else if (in_accept) begin
      phase_q     <= phase_d;
      cur_block_q <= cur_block_d;
      retry_q     <= retry_d;
      timer_q     <= timer_d;
      last_len_q  <= last_len_d;
    end
  end

  // Result register: loads on accept, clears when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_accept || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Every accepted item yields a result the next cycle
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("accepted item produced no result");

  // Entering the done phase always reports a close
  a_close_on_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && phase_d == PH_DONE && phase_q != PH_DONE) |=>
      (out_item_o.action == ACT_CLOSE))
    else $error("transfer ended without close action");

  // Idle means no transfer was ever started
  a_idle_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (cur_block_q == START_BLOCK && retry_q == 4'd0))
    else $error("idle phase with transfer state in use");

  // A send always carries the header and a running end reason
  a_send_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.action == ACT_SEND) |->
      (out_item_o.end_reason == END_RUNNING && out_item_o.packet_length != 10'd0))
    else $error("bad data packet result");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for tftp_read_transfer_control_top: directed and random event items,
// checked field by field against an in-bench model of the transfer state.
// Depends on trtc_pkg and the top level only.

module testbench;
  import trtc_pkg::*;

  localparam int BLOCK_BYTES     = 512;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_OFF_CYCLES = 40;
  localparam int MAX_REPORTS     = 10;
  // Highest mode code; everything past the refused event is not an event
  localparam logic [2:0] EV_UNDEFINED = 3'd7;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_index_i = REG_RETRY_LIMIT;
  logic [15:0] cfg_wdata_i = '0;

  // Model of the transfer state and configuration
  phase_e      m_phase    = PH_IDLE;
  logic [15:0] m_block    = START_BLOCK;
  logic [3:0]  m_retries  = '0;
  logic [15:0] m_timer    = '0;
  logic [9:0]  m_last_len = '0;
  logic [3:0]  m_limit    = RETRY_LIMIT_RST;
  logic [15:0] m_timeout  = TIMEOUT_RST;

  out_item_t transfer_results_q[$];
  out_item_t got_item;
  out_item_t want_item;
  logic      got_valid;

  int  events_sent = 0;
  int  errors      = 0;
  int  cycle_count = 0;
  int  hold_left   = 0;
  int  stall_left  = 0;
  bit  no_idle     = 1'b0;

  tftp_read_transfer_control_top #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // One more retry: resend below the limit, else give up the transfer
  function automatic out_item_t retry_result();
    out_item_t r;
    r = '0;
    m_retries = m_retries + 4'd1;
    if (m_retries < m_limit) begin
      m_timer         = '0;
      r.action        = ACT_SEND;
      r.packet_length = HEADER_BYTES + m_last_len;
    end else begin
      m_phase      = PH_DONE;
      r.action     = ACT_CLOSE;
      r.end_reason = END_RETRIES;
    end
    return r;
  endfunction

  // Apply one event to the model and return the result it should produce
  function automatic out_item_t transfer_step(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.mode)
      EV_START: begin
        m_phase   = PH_FETCH;
        m_block   = START_BLOCK;
        m_retries = '0;
        m_timer   = '0;
        r.action  = ACT_FETCH;
      end
      EV_BLOCK_READY: begin
        if (m_phase == PH_FETCH) begin
          m_last_len = (it.data_length > BLOCK_BYTES) ? 10'(BLOCK_BYTES) : it.data_length;
          m_retries  = '0;
          m_phase    = PH_WAIT;
          m_timer    = '0;
          r.action        = ACT_SEND;
          r.packet_length = HEADER_BYTES + m_last_len;
        end
      end
      EV_TICK: begin
        if (m_phase == PH_WAIT) begin
          if (m_timer != TIMER_MAX) m_timer = m_timer + 16'd1;
          if (m_timer >= m_timeout) r = retry_result();
        end
      end
      EV_PACKET: begin
        if (m_phase == PH_WAIT) begin
          if (it.packet_opcode != OPC_ACK || it.ack_block < m_block) begin
            r = retry_result();
          end else if (m_last_len == 10'(BLOCK_BYTES)) begin
            m_block  = m_block + 16'd1;
            m_phase  = PH_FETCH;
            r.action = ACT_FETCH;
          end else begin
            m_phase      = PH_DONE;
            r.action     = ACT_CLOSE;
            r.end_reason = END_FINISHED;
          end
        end
      end
      EV_REFUSED: begin
        if (m_phase == PH_FETCH || m_phase == PH_WAIT) begin
          m_phase      = PH_DONE;
          r.action     = ACT_CLOSE;
          r.end_reason = END_REFUSED;
        end
      end
      default: begin
      end
    endcase
    r.block_number = m_block;
    return r;
  endfunction

  // Event item of the given kind; fields it does not use are random
  function automatic in_item_t ev_item(logic [2:0] mode);
    in_item_t it;
    it.mode          = mode;
    it.data_length   = 10'($urandom);
    it.packet_opcode = 16'($urandom);
    it.ack_block     = 16'($urandom);
    return it;
  endfunction

  // Offer one item, wait for it to be taken, record its expected result.
  // Entered and left on a rising edge; valid stays up for back-to-back items.
  task automatic send_event(in_item_t it);
    int   gap;
    logic took;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    transfer_results_q.push_back(transfer_step(it));
    events_sent++;
  endtask

  // Stop offering and wait until every result is back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (transfer_results_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_RETRY_LIMIT) m_limit = value[3:0];
    else m_timeout = value;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [3:0] limit, logic [15:0] ticks);
    wait_idle();
    write_reg(REG_RETRY_LIMIT, {12'd0, limit});
    write_reg(REG_TIMEOUT_TICKS, ticks);
  endtask

  // One transfer from start until it closes or wanders off: mostly proper
  // acknowledgements and ticks, with stale, foreign and refused packets mixed in
  task automatic run_transfer();
    in_item_t it;
    int       guard;
    int       pick;
    send_event(ev_item(EV_START));
    while (m_phase == PH_FETCH) begin
      if ($urandom_range(0, 19) == 0) send_event(ev_item(3'($urandom_range(0, 7))));
      it = ev_item(EV_BLOCK_READY);
      case ($urandom_range(0, 9))
        0: it.data_length = 10'($urandom_range(0, BLOCK_BYTES - 1));
        1: it.data_length = 10'($urandom_range(BLOCK_BYTES + 1, 1023));
        default: it.data_length = 10'(BLOCK_BYTES);
      endcase
      send_event(it);
      guard = 0;
      while (m_phase == PH_WAIT && guard < 40) begin
        guard++;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          it = ev_item(EV_TICK);
        end else if (pick < 52) begin
          it = ev_item(EV_PACKET);
          if (it.packet_opcode == OPC_ACK) it.packet_opcode = ~OPC_ACK;
        end else if (pick < 60) begin
          it = ev_item(EV_PACKET);
          it.packet_opcode = OPC_ACK;
          it.ack_block     = 16'($urandom_range(0, m_block - 1));
        end else if (pick < 62) begin
          it = ev_item(EV_REFUSED);
        end else begin
          it = ev_item(EV_PACKET);
          it.packet_opcode = OPC_ACK;
          it.ack_block     = ($urandom_range(0, 3) == 0) ?
                             16'($urandom_range(m_block, 16'hFFFF)) : m_block;
        end
        send_event(it);
      end
    end
  endtask

  // Events that do not belong to the idle phase, and undefined codes
  task automatic test_idle_events();
    send_event(ev_item(EV_BLOCK_READY));
    send_event(ev_item(EV_TICK));
    send_event(ev_item(EV_PACKET));
    send_event(ev_item(EV_REFUSED));
    send_event(ev_item(EV_UNDEFINED));
  endtask

  // Data and acknowledgement exchange at the reset configuration
  task automatic test_block_exchange();
    in_item_t it;
    send_event(ev_item(EV_START));
    // oversized length saturates to a full block
    it = ev_item(EV_BLOCK_READY);
    it.data_length = 10'h3FF;
    send_event(it);
    // foreign opcode, then a stale ack: both resend
    it = ev_item(EV_PACKET);
    it.packet_opcode = 16'hFFFF;
    send_event(it);
    it.packet_opcode = OPC_ACK;
    it.ack_block     = 16'h0000;
    send_event(it);
    // ack ahead of the current block still counts
    it.ack_block = 16'hFFFF;
    send_event(it);
    it = ev_item(EV_BLOCK_READY);
    it.data_length = '0;
    send_event(it);
    send_event(ev_item(EV_TICK));
    // ack of a short block ends the transfer
    it = ev_item(EV_PACKET);
    it.packet_opcode = OPC_ACK;
    it.ack_block     = 16'd2;
    send_event(it);
    send_event(ev_item(EV_TICK));
    send_event(ev_item(EV_REFUSED));
    send_event(ev_item(EV_BLOCK_READY));
    // restart while waiting, then refusal while fetching
    send_event(ev_item(EV_START));
    it = ev_item(EV_BLOCK_READY);
    it.data_length = 10'd511;
    send_event(it);
    send_event(ev_item(EV_START));
    send_event(ev_item(EV_REFUSED));
  endtask

  // Retry limit and timeout at their extremes, zero included
  task automatic test_retry_limits();
    in_item_t it;
    it = ev_item(EV_BLOCK_READY);
    it.data_length = 10'(BLOCK_BYTES);
    set_config(4'd1, 16'd1);
    send_event(ev_item(EV_START));
    send_event(it);
    send_event(ev_item(EV_TICK));
    set_config(4'd0, 16'd0);
    send_event(ev_item(EV_START));
    send_event(it);
    send_event(ev_item(EV_TICK));
    set_config(4'd15, 16'hFFFF);
    send_event(ev_item(EV_START));
    send_event(it);
    send_event(ev_item(EV_TICK));
  endtask

  // Random transfers over a series of settings
  task automatic test_random_transfers();
    int goal;
    for (int round = 0; round < 6; round++) begin
      case (round)
        0: set_config(RETRY_LIMIT_RST, 16'd3);
        1: set_config(4'd1, 16'd1);
        2: set_config(4'd15, 16'd2);
        3: set_config(4'd0, 16'd0);
        4: set_config(4'd15, 16'hFFFF);
        default: set_config(4'($urandom_range(1, 15)), 16'($urandom_range(1, 6)));
      endcase
      goal = events_sent + 135;
      while (events_sent < goal) begin
        if ($urandom_range(0, 9) == 0) send_event(ev_item(3'($urandom_range(0, 7))));
        else run_transfer();
      end
    end
  endtask

  // Receiver holds off for a long stretch while items keep coming
  task automatic test_output_stall();
    int goal;
    set_config(4'd3, 16'd2);
    hold_left = HOLD_OFF_CYCLES;
    goal = events_sent + 30;
    while (events_sent < goal) run_transfer();
  endtask

  // Full rate on both sides to the end
  task automatic test_steady_stream();
    int goal;
    no_idle = 1'b1;
    goal = events_sent + 60;
    while (events_sent < goal) begin
      if ($urandom_range(0, 9) == 0) send_event(ev_item(3'($urandom_range(0, 7))));
      else run_transfer();
    end
  endtask

  // Result side: random stall bursts, plus the long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each result taken with the oldest pending one
  always begin
    @(negedge clk_i);
    got_valid = out_valid_o && out_ready_i;
    got_item  = out_item_o;
    @(posedge clk_i);
    if (got_valid) begin
      if (transfer_results_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with no event pending: act %0d blk %0d len %0d end %0d",
                   $realtime, got_item.action, got_item.block_number,
                   got_item.packet_length, got_item.end_reason);
      end else begin
        want_item = transfer_results_q.pop_front();
        if (got_item.action !== want_item.action ||
            got_item.block_number !== want_item.block_number ||
            got_item.packet_length !== want_item.packet_length ||
            got_item.end_reason !== want_item.end_reason) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $write("%0t: expected act %0d blk %0d len %0d end %0d,",
                   $realtime, want_item.action, want_item.block_number,
                   want_item.packet_length, want_item.end_reason);
            $display(" got act %0d blk %0d len %0d end %0d",
                     got_item.action, got_item.block_number,
                     got_item.packet_length, got_item.end_reason);
          end
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_events();
    test_block_exchange();
    test_retry_limits();
    test_random_transfers();
    test_output_stall();
    test_steady_stream();
    wait_idle();
    repeat (4) @(posedge clk_i);
    if (errors == 0 && transfer_results_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/trtc_pkg.sv
rtl/tftp_read_transfer_control_top.sv
tb/sv/testbench.sv
